FILE: design/circle_canvas_rasterizer_core_assert.svh
// assertion macros used by the canvas rasterizer core
`ifndef CIRCLE_CANVAS_RASTERIZER_CORE_ASSERT_SVH
`define CIRCLE_CANVAS_RASTERIZER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CCR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define CCR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ccr_pkg.sv
// shared types and constants of the circle canvas rasterizer
package ccr_pkg;

	// default largest canvas side
	localparam int MAX_SIDE_DEF = 256;

	// field widths
	localparam int COORD_W    = 20;
	localparam int CHAR_W     = 8;
	localparam int SIDE_CFG_W = 9;
	localparam int SQ_W       = 2 * (COORD_W - 1);

	// fixed point: eight fraction bits
	localparam int Q_FRAC = 8;
	localparam int Q_ONE  = 1 << Q_FRAC;

	// shape characters
	localparam logic [CHAR_W-1:0] CHAR_OUTLINE = 8'h63;
	localparam logic [CHAR_W-1:0] CHAR_FILLED  = 8'h43;

	// register reset values
	localparam logic [SIDE_CFG_W-1:0] WIDTH_RST  = 9'd1;
	localparam logic [SIDE_CFG_W-1:0] HEIGHT_RST = 9'd1;
	localparam logic [CHAR_W-1:0]     BG_RST     = 8'd32;

	// register indexes
	localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
	localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BACKGROUND    = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_DRAW  = 2'd1,
		OP_READ  = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SETUP,
		ST_DRAW,
		ST_DRAIN,
		ST_READ
	} state_t;

	// per-draw constants handed to the distance pipeline
	typedef struct packed {
		logic            filled;
		logic            rm_neg;
		logic [SQ_W-1:0] r2;
		logic [SQ_W-1:0] rm2;
	} draw_ctl_t;

endpackage

FILE: design/ccr_dist_pipe.sv
// squared-distance pixel test pipeline for circle drawing
module ccr_dist_pipe #(
	parameter int SIDE_W = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pix_vld,
	input  logic [SIDE_W-1:0]                    pix_col,
	input  logic [SIDE_W-1:0]                    pix_row,
	input  logic signed [ccr_pkg::COORD_W-1:0]   cx,
	input  logic signed [ccr_pkg::COORD_W-1:0]   cy,
	input  ccr_pkg::draw_ctl_t                   ctl,
	output logic                                 wr_en,
	output logic [2*SIDE_W-1:0]                  wr_addr,
	output logic                                 busy
);

	localparam int POS_W = SIDE_W + ccr_pkg::Q_FRAC;
	localparam int DX_W  = ((POS_W > ccr_pkg::COORD_W - 1) ? POS_W : ccr_pkg::COORD_W - 1) + 2;
	localparam int SQ2_W = 2 * DX_W;
	localparam int D2_W  = SQ2_W + 1;

	logic                     vld_s1, vld_s2;
	logic [2*SIDE_W-1:0]      addr_s1, addr_s2;
	logic signed [DX_W-1:0]   dx_s1, dy_s1;
	logic [SQ2_W-1:0]         sqx_s2, sqy_s2;

	logic signed [DX_W-1:0]   pos_x, pos_y, cx_ext, cy_ext;
	logic signed [SQ2_W-1:0]  dx_ext, dy_ext, sqx_c, sqy_c;
	logic [D2_W-1:0]          d2, r2_ext, rm2_ext;
	logic                     in_circle, border;

	// pixel position in fixed point minus the centre
	assign pos_x  = $signed(DX_W'(pix_col) << ccr_pkg::Q_FRAC);
	assign pos_y  = $signed(DX_W'(pix_row) << ccr_pkg::Q_FRAC);
	assign cx_ext = {{(DX_W - ccr_pkg::COORD_W){cx[ccr_pkg::COORD_W-1]}}, cx};
	assign cy_ext = {{(DX_W - ccr_pkg::COORD_W){cy[ccr_pkg::COORD_W-1]}}, cy};

	// offsets squared
	assign dx_ext = {{DX_W{dx_s1[DX_W-1]}}, dx_s1};
	assign dy_ext = {{DX_W{dy_s1[DX_W-1]}}, dy_s1};
	assign sqx_c  = dx_ext * dx_ext;
	assign sqy_c  = dy_ext * dy_ext;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= pix_vld;
			vld_s2 <= vld_s1;
		end
	end

	// offset stage and square stage
	always_ff @(posedge clk) begin
		dx_s1   <= pos_x - cx_ext;
		dy_s1   <= pos_y - cy_ext;
		addr_s1 <= {pix_row, pix_col};
		sqx_s2  <= $unsigned(sqx_c);
		sqy_s2  <= $unsigned(sqy_c);
		addr_s2 <= addr_s1;
	end

	// sum and compare against radius and inner radius
	assign d2        = D2_W'(sqx_s2) + D2_W'(sqy_s2);
	assign r2_ext    = D2_W'(ctl.r2);
	assign rm2_ext   = D2_W'(ctl.rm2);
	assign in_circle = (d2 <= r2_ext);
	assign border    = ctl.rm_neg || (d2 > rm2_ext);

	assign wr_en   = vld_s2 && in_circle && (border || ctl.filled);
	assign wr_addr = addr_s2;
	assign busy    = vld_s1 || vld_s2;

endmodule

FILE: design/circle_canvas_rasterizer_core.sv
// circle canvas rasterizer: control, canvas memory and configuration
//
// Items arrive on the s_ stream: s_tuser holds the opcode (clear, draw, read),
// s_tdata the circle and pixel fields. Only a read gives a result, on the m_
// stream: m_tdata the stored character, m_tuser the corrupted flag.
// Registers (width, height, background) are written on the cfg_ channel,
// which is always ready; write them only while the block is idle.
// One item is worked at a time (W, H the used width and height). A clear holds
// s_tready low while it sweeps the W*H pixels after the transfer, a draw through
// the setup state, the sweep and the pipeline drain, an ignored or invalid draw
// through the setup state alone, and a read through its read state, or longer
// while an earlier result still sits untaken in the output register. The sweep
// length follows from the single canvas write port, one pixel per cycle.
// A read result passes a read data register and then sits in an output
// register; a stalled receiver holds it, and the next clear or draw
// may still be taken meanwhile; only a further read waits for it to free up.
// Reset clears the control state and the corrupted flag and sets width 1,
// height 1 and background 32. Canvas contents are undefined until a clear.
module circle_canvas_rasterizer_core #(
	parameter int MAX_SIDE = ccr_pkg::MAX_SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// center_x[19:0], center_y[39:20], radius[59:40], shape_char[67:60],
	// paint_char[75:68], pixel_col[83:76], pixel_row[91:84], zero fill
	input  logic [95:0] s_tdata,
	// opcode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pixel_char[7:0]
	output logic [7:0]  m_tdata,
	// corrupted[0]
	output logic [0:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	`include "circle_canvas_rasterizer_core_assert.svh"

	localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int CNT_W  = ($clog2(MAX_SIDE + 1) > ccr_pkg::SIDE_CFG_W) ?
		$clog2(MAX_SIDE + 1) : ccr_pkg::SIDE_CFG_W;
	localparam int ADDR_W = 2 * SIDE_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int CW     = ccr_pkg::COORD_W;
	localparam int CH     = ccr_pkg::CHAR_W;

	ccr_pkg::state_t    state_q, state_d;
	ccr_pkg::opcode_t   op;
	ccr_pkg::draw_ctl_t ctl_q;

	// configuration registers
	logic [ccr_pkg::SIDE_CFG_W-1:0] width_q, height_q;
	logic [CH-1:0]                  bg_q;

	// captured draw item
	logic signed [CW-1:0] cx_q, cy_q, rad_q;
	logic [CH-1:0]        shape_q, paint_q;

	// sweep counters and status
	logic [SIDE_W-1:0] col_q, row_q;
	logic              corrupt_q;
	logic              rd_in_area_q;
	logic [CH-1:0]     rd_data_q;
	logic              m_valid_q;
	logic [CH-1:0]     m_data_q;
	logic              m_user_q;

	// canvas store
	logic [CH-1:0] canvas_mem [DEPTH];

	logic [CNT_W-1:0]  eff_w, eff_h, col_in, row_in;
	logic              empty, col_last, row_last, sweep_last;
	logic              sweep_start, sweep_step, clr_corrupt, set_corrupt;
	logic              cap_draw, load_ctl, clear_we, pix_vld, rd_issue, out_load;
	logic              draw_ok, rd_in_area;
	logic signed [CW:0] rm_full;
	logic              pipe_we, pipe_busy;
	logic [ADDR_W-1:0] pipe_addr, rd_addr, mem_waddr;
	logic              mem_we;
	logic [CH-1:0]     mem_wdata;

	assign op = ccr_pkg::opcode_t'(s_tuser);

	// used sides saturate at the largest side
	assign eff_w = (CNT_W'(width_q) > CNT_W'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : CNT_W'(width_q);
	assign eff_h = (CNT_W'(height_q) > CNT_W'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : CNT_W'(height_q);
	assign empty = (eff_w == '0) || (eff_h == '0);

	assign col_last   = (CNT_W'(col_q) + CNT_W'(1)) == eff_w;
	assign row_last   = (CNT_W'(row_q) + CNT_W'(1)) == eff_h;
	assign sweep_last = col_last && row_last;

	// read address and area check
	assign col_in     = CNT_W'(s_tdata[83:76]);
	assign row_in     = CNT_W'(s_tdata[91:84]);
	assign rd_in_area = (col_in < eff_w) && (row_in < eff_h);
	assign rd_addr    = {row_in[SIDE_W-1:0], col_in[SIDE_W-1:0]};

	// circle validity and inner radius
	assign draw_ok = !rad_q[CW-1] && (rad_q != '0) &&
		((shape_q == ccr_pkg::CHAR_OUTLINE) || (shape_q == ccr_pkg::CHAR_FILLED));
	assign rm_full = {rad_q[CW-1], rad_q} - (CW + 1)'(ccr_pkg::Q_ONE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		sweep_start = 1'b0;
		sweep_step  = 1'b0;
		clr_corrupt = 1'b0;
		set_corrupt = 1'b0;
		cap_draw    = 1'b0;
		load_ctl    = 1'b0;
		clear_we    = 1'b0;
		pix_vld     = 1'b0;
		rd_issue    = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ccr_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (op)
						ccr_pkg::OP_CLEAR: begin
							clr_corrupt = 1'b1;
							sweep_start = 1'b1;
							if (!empty) begin
								state_d = ccr_pkg::ST_CLEAR;
							end
						end
						ccr_pkg::OP_DRAW: begin
							cap_draw    = 1'b1;
							sweep_start = 1'b1;
							state_d     = ccr_pkg::ST_SETUP;
						end
						ccr_pkg::OP_READ: begin
							rd_issue = 1'b1;
							state_d  = ccr_pkg::ST_READ;
						end
						default: ;
					endcase
				end
			end
			ccr_pkg::ST_CLEAR: begin
				clear_we   = 1'b1;
				sweep_step = 1'b1;
				if (sweep_last) begin
					state_d = ccr_pkg::ST_IDLE;
				end
			end
			ccr_pkg::ST_SETUP: begin
				priority if (corrupt_q) begin
					state_d = ccr_pkg::ST_IDLE;
				end else if (!draw_ok) begin
					set_corrupt = 1'b1;
					state_d     = ccr_pkg::ST_IDLE;
				end else if (empty) begin
					state_d = ccr_pkg::ST_IDLE;
				end else begin
					load_ctl = 1'b1;
					state_d  = ccr_pkg::ST_DRAW;
				end
			end
			ccr_pkg::ST_DRAW: begin
				pix_vld    = 1'b1;
				sweep_step = 1'b1;
				if (sweep_last) begin
					state_d = ccr_pkg::ST_DRAIN;
				end
			end
			ccr_pkg::ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ccr_pkg::ST_IDLE;
				end
			end
			ccr_pkg::ST_READ: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ccr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ccr_pkg::ST_IDLE;
			end
		endcase
	end

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ccr_pkg::WIDTH_RST;
			height_q <= ccr_pkg::HEIGHT_RST;
			bg_q     <= ccr_pkg::BG_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ccr_pkg::REG_CANVAS_WIDTH:  width_q  <= cfg_data;
				ccr_pkg::REG_CANVAS_HEIGHT: height_q <= cfg_data;
				ccr_pkg::REG_BACKGROUND:    bg_q     <= cfg_data[CH-1:0];
				default: ;
			endcase
		end
	end

	// sticky corrupted flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corrupt_q <= 1'b0;
		end else if (clr_corrupt) begin
			corrupt_q <= 1'b0;
		end else if (set_corrupt) begin
			corrupt_q <= 1'b1;
		end
	end

	// sweep counters, row-major
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (sweep_start) begin
			col_q <= '0;
			row_q <= '0;
		end else if (sweep_step) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_q + SIDE_W'(1);
			end else begin
				col_q <= col_q + SIDE_W'(1);
			end
		end
	end

	// draw item capture and per-draw constants
	always_ff @(posedge clk) begin
		if (cap_draw) begin
			cx_q    <= s_tdata[19:0];
			cy_q    <= s_tdata[39:20];
			rad_q   <= s_tdata[59:40];
			shape_q <= s_tdata[67:60];
			paint_q <= s_tdata[75:68];
		end
		if (load_ctl) begin
			ctl_q.filled <= (shape_q == ccr_pkg::CHAR_FILLED);
			ctl_q.rm_neg <= rm_full[CW];
			ctl_q.r2     <= ccr_pkg::SQ_W'(rad_q[CW-2:0]) * ccr_pkg::SQ_W'(rad_q[CW-2:0]);
			ctl_q.rm2    <= ccr_pkg::SQ_W'(rm_full[CW-2:0]) * ccr_pkg::SQ_W'(rm_full[CW-2:0]);
		end
	end

	ccr_dist_pipe #(
		.SIDE_W (SIDE_W)
	) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_vld (pix_vld),
		.pix_col (col_q),
		.pix_row (row_q),
		.cx      (cx_q),
		.cy      (cy_q),
		.ctl     (ctl_q),
		.wr_en   (pipe_we),
		.wr_addr (pipe_addr),
		.busy    (pipe_busy)
	);

	// write port: clear sweep or painted pixel
	assign mem_we    = clear_we || pipe_we;
	assign mem_waddr = clear_we ? {row_q, col_q} : pipe_addr;
	assign mem_wdata = clear_we ? bg_q : paint_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			canvas_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_issue) begin
			rd_data_q    <= canvas_mem[rd_addr];
			rd_in_area_q <= rd_in_area;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= rd_in_area_q ? rd_data_q : '0;
			m_user_q <= corrupt_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	// checks
	`CCR_ASSERT_NOW(a_no_accept_busy, s_tvalid && s_tready, !pipe_busy,
		"item transfer while draw pipeline still writing")
	`CCR_ASSERT_NOW(a_no_write_in_read, state_q == ccr_pkg::ST_READ, !mem_we,
		"canvas write during a pending read")
	`CCR_ASSERT_NOW(a_out_free, out_load, !m_valid_q || m_tready,
		"read result overwrote an untaken result")
	`CCR_ASSERT_NEXT(a_corrupt_sticky, corrupt_q && !clr_corrupt, corrupt_q,
		"corrupted flag dropped without a clear")

endmodule

FILE: test/testbench.sv
// self-checking testbench for the circle canvas rasterizer core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 12;
	localparam int LIMIT_CYCLES = 4_000_000;
	localparam int SIDE         = ccr_pkg::MAX_SIDE_DEF;
	localparam int IDLE_PCT     = 10;

	// opcode with no meaning, and a register index with no register behind it
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [7:0] pixel_char;
		logic       corrupted;
	} read_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// center_x, center_y, radius, shape_char, paint_char, pixel_col, pixel_row, zero fill
	logic [95:0] s_tdata;
	// opcode
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// pixel_char
	logic [7:0]  m_tdata;
	// corrupted
	logic [0:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;

	// canvas predictor state
	logic [7:0]   canvas_model [0:SIDE*SIDE-1];
	bit           pixel_written [0:SIDE*SIDE-1];
	logic         corrupt_model;
	logic [8:0]   width_reg;
	logic [8:0]   height_reg;
	logic [7:0]   bg_reg;

	read_result_t pending_reads [$];
	int           mismatch_count;
	bit           calm;
	int           hold_request;

	circle_canvas_rasterizer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// run limit
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("testbench: FAIL");
		$finish;
	end

	// side in use, saturated at the largest canvas
	function automatic int used_side(input logic [8:0] v);
		return (v > SIDE) ? SIDE : int'(v);
	endfunction

	// update the canvas predictor for one accepted item
	task automatic predict_canvas_item(input logic [1:0] op, input logic signed [19:0] cx,
			input logic signed [19:0] cy, input logic signed [19:0] rad,
			input logic [7:0] shape, input logic [7:0] paint,
			input logic [7:0] col, input logic [7:0] row);
		int w, h, r, c;
		longint cxs, cys, rs, r2, rm, rm2, dx, dy, d2;
		bit filled;
		read_result_t res;
		w = used_side(width_reg);
		h = used_side(height_reg);
		case (op)
			ccr_pkg::OP_CLEAR: begin
				for (r = 0; r < h; r++)
					for (c = 0; c < w; c++) begin
						canvas_model[r*SIDE + c] = bg_reg;
						pixel_written[r*SIDE + c] = 1'b1;
					end
				corrupt_model = 1'b0;
			end
			ccr_pkg::OP_DRAW: begin
				// sticky flag: nothing is drawn until the next clear
				if (!corrupt_model) begin
					if (rad <= 0 || (shape != ccr_pkg::CHAR_OUTLINE &&
							shape != ccr_pkg::CHAR_FILLED)) begin
						corrupt_model = 1'b1;
					end else begin
						filled = (shape == ccr_pkg::CHAR_FILLED);
						cxs = cx;
						cys = cy;
						rs = rad;
						r2 = rs * rs;
						rm = rs - ccr_pkg::Q_ONE;
						rm2 = (rm >= 0) ? rm * rm : 0;
						for (r = 0; r < h; r++) begin
							dy = longint'(r) * ccr_pkg::Q_ONE - cys;
							for (c = 0; c < w; c++) begin
								dx = longint'(c) * ccr_pkg::Q_ONE - cxs;
								d2 = dx * dx + dy * dy;
								if (d2 <= r2 && (filled || rm < 0 || d2 > rm2))
									canvas_model[r*SIDE + c] = paint;
							end
						end
					end
				end
			end
			ccr_pkg::OP_READ: begin
				res.pixel_char = (col < w && row < h) ? canvas_model[row*SIDE + col] : 8'd0;
				res.corrupted = corrupt_model;
				pending_reads.push_back(res);
			end
			default: begin
			end
		endcase
	endtask

	// offer one item and wait for its transfer
	task automatic send_item(input logic [1:0] op, input logic [19:0] cx, input logic [19:0] cy,
			input logic [19:0] rad, input logic [7:0] shape, input logic [7:0] paint,
			input logic [7:0] col, input logic [7:0] row);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'b0, row, col, paint, shape, rad, cy, cx};
		do @(posedge clk); while (!s_tready);
		predict_canvas_item(op, cx, cy, rad, shape, paint, col, row);
	endtask

	// unused fields carry random content
	task automatic send_clear();
		send_item(ccr_pkg::OP_CLEAR, 20'($urandom), 20'($urandom), 20'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic send_draw(input logic [19:0] cx, input logic [19:0] cy,
			input logic [19:0] rad, input logic [7:0] shape, input logic [7:0] paint);
		send_item(ccr_pkg::OP_DRAW, cx, cy, rad, shape, paint, 8'($urandom), 8'($urandom));
	endtask

	task automatic send_read(input logic [7:0] col, input logic [7:0] row);
		send_item(ccr_pkg::OP_READ, 20'($urandom), 20'($urandom), 20'($urandom),
			8'($urandom), 8'($urandom), col, row);
	endtask

	// register write over the configuration channel
	task automatic write_reg(input logic [1:0] idx, input logic [8:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ccr_pkg::REG_CANVAS_WIDTH:  width_reg = value;
			ccr_pkg::REG_CANVAS_HEIGHT: height_reg = value;
			ccr_pkg::REG_BACKGROUND:    bg_reg = value[7:0];
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	// sender pauses until every read result has come back
	task automatic wait_reads_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_reads.size() != 0) @(posedge clk);
	endtask

	// a clear or draw gives no result, so let its sweep run out as well
	task automatic wait_canvas_idle();
		wait_reads_drained();
		repeat (used_side(width_reg) * used_side(height_reg) + 16) @(posedge clk);
	endtask

	// one random item, mostly well-formed circles and reads of the canvas
	task automatic send_random_item();
		int w, h, pick, span;
		logic [19:0] cx, cy, rad;
		logic [7:0] shape, col, row;
		w = used_side(width_reg);
		h = used_side(height_reg);
		span = ((w > h) ? w : h) + 2;
		pick = $urandom_range(99);
		if (pick < 8) begin
			send_clear();
		end else if (pick < 48) begin
			cx = ($urandom_range(4) == 0) ? 20'($urandom) :
				20'(int'($urandom_range(0, span * ccr_pkg::Q_ONE)) - ccr_pkg::Q_ONE);
			cy = ($urandom_range(4) == 0) ? 20'($urandom) :
				20'(int'($urandom_range(0, span * ccr_pkg::Q_ONE)) - ccr_pkg::Q_ONE);
			rad = ($urandom_range(15) == 0) ? 20'($urandom) :
				20'($urandom_range(1, span * ccr_pkg::Q_ONE));
			if ($urandom_range(19) == 0)
				shape = 8'($urandom);
			else
				shape = $urandom_range(1) ? ccr_pkg::CHAR_FILLED : ccr_pkg::CHAR_OUTLINE;
			send_draw(cx, cy, rad, shape, 8'($urandom));
		end else if (pick < 96) begin
			if (w == 0 || h == 0 || $urandom_range(9) == 0) begin
				col = 8'($urandom);
				row = 8'($urandom);
			end else begin
				col = 8'($urandom_range(0, w - 1));
				row = 8'($urandom_range(0, h - 1));
			end
			// never read a pixel that no clear has written
			if (col < w && row < h && !pixel_written[row*SIDE + col])
				send_clear();
			else
				send_read(col, row);
		end else begin
			send_item(OP_UNUSED, 20'($urandom), 20'($urandom), 20'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	// state after reset: one pixel, space background
	task automatic test_reset_state();
		send_clear();
		send_read(8'd0, 8'd0);
		send_read(8'd255, 8'd255);
		send_item(OP_UNUSED, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
	endtask

	// outline, filled, sub-pixel radius and extreme coordinates
	task automatic test_shapes();
		wait_canvas_idle();
		write_reg(ccr_pkg::REG_CANVAS_WIDTH, 9'd16);
		write_reg(ccr_pkg::REG_CANVAS_HEIGHT, 9'd12);
		write_reg(ccr_pkg::REG_BACKGROUND, 9'h02E);
		send_clear();
		send_draw(20'd2048, 20'd1536, 20'd1280, ccr_pkg::CHAR_OUTLINE, 8'h23);
		send_draw(20'd896, 20'd1088, 20'd704, ccr_pkg::CHAR_FILLED, 8'h2A);
		send_draw(20'd3072, 20'd768, 20'd128, ccr_pkg::CHAR_OUTLINE, 8'h6F);
		send_draw(20'h80000, 20'h80000, 20'h7FFFF, ccr_pkg::CHAR_FILLED, 8'hFF);
		send_draw(20'h7FFFF, 20'h7FFFF, 20'd1, ccr_pkg::CHAR_OUTLINE, 8'h00);
		send_read(8'd8, 8'd1);
		send_read(8'd8, 8'd6);
		send_read(8'd3, 8'd4);
		send_read(8'd12, 8'd3);
		send_read(8'd16, 8'd0);
		send_read(8'd0, 8'd12);
	endtask

	// invalid circles set the sticky flag until the next clear
	task automatic test_invalid_circles();
		send_draw(20'd2048, 20'd1536, 20'd0, ccr_pkg::CHAR_FILLED, 8'h41);
		send_read(8'd8, 8'd6);
		send_draw(20'd2048, 20'd1536, 20'd1024, ccr_pkg::CHAR_FILLED, 8'h42);
		send_read(8'd8, 8'd6);
		send_clear();
		send_draw(20'd2048, 20'd1536, 20'd1024, 8'h78, 8'h43);
		send_read(8'd15, 8'd11);
		send_clear();
		send_draw(20'd1024, 20'd1024, 20'h80000, ccr_pkg::CHAR_FILLED, 8'h44);
		send_read(8'd4, 8'd4);
	endtask

	// empty canvas, then the largest one with a saturated width
	task automatic test_canvas_sizes();
		wait_canvas_idle();
		write_reg(ccr_pkg::REG_CANVAS_WIDTH, 9'd0);
		write_reg(ccr_pkg::REG_CANVAS_HEIGHT, 9'd5);
		write_reg(REG_UNUSED, 9'h1FF);
		send_clear();
		send_draw(20'd0, 20'd0, 20'd512, ccr_pkg::CHAR_FILLED, 8'h55);
		send_read(8'd0, 8'd0);
		send_read(8'd3, 8'd2);
		wait_canvas_idle();
		write_reg(ccr_pkg::REG_CANVAS_WIDTH, 9'h1FF);
		write_reg(ccr_pkg::REG_CANVAS_HEIGHT, 9'd256);
		write_reg(ccr_pkg::REG_BACKGROUND, 9'h1A5);
		send_clear();
		send_draw(20'd32768, 20'd32768, 20'd25600, ccr_pkg::CHAR_FILLED, 8'h40);
		send_draw(20'd65280, 20'd0, 20'd15488, ccr_pkg::CHAR_OUTLINE, 8'h7E);
		send_read(8'd255, 8'd255);
		send_read(8'd128, 8'd128);
		send_read(8'd0, 8'd0);
		send_read(8'd200, 8'd5);
		send_read(8'd255, 8'd60);
	endtask

	// receiver holds off while reads pile up behind the output register
	task automatic test_output_stall();
		int i;
		wait_canvas_idle();
		write_reg(ccr_pkg::REG_CANVAS_WIDTH, 9'd8);
		write_reg(ccr_pkg::REG_CANVAS_HEIGHT, 9'd8);
		write_reg(ccr_pkg::REG_BACKGROUND, 9'($urandom));
		send_clear();
		send_draw(20'd1024, 20'd1024, 20'd768, ccr_pkg::CHAR_FILLED, 8'($urandom));
		hold_request = 300;
		for (i = 0; i < 8; i++)
			send_read(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)));
		send_draw(20'd512, 20'd1536, 20'd640, ccr_pkg::CHAR_OUTLINE, 8'($urandom));
		send_read(8'd2, 8'd6);
		wait_reads_drained();
		for (i = 0; i < 4; i++)
			send_random_item();
	endtask

	// random phases over random canvas settings, one of them without idling
	task automatic test_random_items();
		int phase, i;
		for (phase = 0; phase < 4; phase++) begin
			wait_canvas_idle();
			calm = (phase == 1);
			write_reg(ccr_pkg::REG_CANVAS_WIDTH, 9'($urandom_range(1, 24)));
			write_reg(ccr_pkg::REG_CANVAS_HEIGHT, 9'($urandom_range(1, 24)));
			write_reg(ccr_pkg::REG_BACKGROUND, 9'($urandom));
			send_clear();
			for (i = 0; i < 10; i++)
				send_random_item();
		end
		calm = 1'b0;
	endtask

	// result receiver: random stalls plus a counted hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// compare each result transfer with the oldest pending read
	initial begin
		read_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_reads.size() == 0) begin
					$error("unexpected result: pixel_char %0d corrupted %0d", m_tdata, m_tuser[0]);
					mismatch_count++;
				end else begin
					want = pending_reads.pop_front();
					if (m_tdata !== want.pixel_char) begin
						$error("pixel_char mismatch: expected %0d, actual %0d",
							want.pixel_char, m_tdata);
						mismatch_count++;
					end
					if (m_tuser[0] !== want.corrupted) begin
						$error("corrupted mismatch: expected %0d, actual %0d",
							want.corrupted, m_tuser[0]);
						mismatch_count++;
					end
				end
			end
		end
	end

	// main sequence
	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ccr_pkg::OP_CLEAR;
		cfg_valid <= 1'b0;
		cfg_index <= ccr_pkg::REG_CANVAS_WIDTH;
		cfg_data <= '0;
		arst_n <= 1'b0;
		mismatch_count = 0;
		calm = 1'b0;
		hold_request = 0;
		corrupt_model = 1'b0;
		width_reg = ccr_pkg::WIDTH_RST;
		height_reg = ccr_pkg::HEIGHT_RST;
		bg_reg = ccr_pkg::BG_RST;
		for (int i = 0; i < SIDE * SIDE; i++) begin
			canvas_model[i] = 8'd0;
			pixel_written[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_shapes();
		test_invalid_circles();
		test_canvas_sizes();
		test_output_stall();
		test_random_items();
		wait_canvas_idle();

		if (mismatch_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
